>>> rtl/core/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, disabled while reset is active
`define ASSERT_CLK(lbl, clk_sig, rst_sig, prop, msg) \
    lbl: assert property (@(posedge clk_sig) disable iff (!rst_sig) prop) \
        else $error(msg);

// clocked check that also holds during reset
`define ASSERT_ALWAYS(lbl, clk_sig, prop, msg) \
    lbl: assert property (@(posedge clk_sig) prop) else $error(msg);

`endif

>>> rtl/core/irc_tok_pkg.sv
// types and constants for the irc line tokenizer
`timescale 1ns / 1ps

package irc_tok_pkg;

    localparam int POS_W = 10;
    localparam logic [POS_W-1:0] POS_SAT = 10'd1023;

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // byte classification codes
    localparam logic [1:0] BK_SEP     = 2'd0;
    localparam logic [1:0] BK_CMD     = 2'd1;
    localparam logic [1:0] BK_PARAM   = 2'd2;
    localparam logic [1:0] BK_DROPPED = 2'd3;

    // completed word codes
    localparam logic [1:0] WK_IGNORED = 2'd0;
    localparam logic [1:0] WK_CMD     = 2'd1;
    localparam logic [1:0] WK_PARAM   = 2'd2;
    localparam logic [1:0] WK_DROPPED = 2'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } tok_in_t;

    typedef struct packed {
        logic [7:0] byte_out;
        logic [1:0] byte_kind;
        logic [3:0] param_index;
        logic [8:0] byte_offset;
        logic       word_done;
        logic [1:0] word_kind;
        logic [9:0] word_length;
        logic [3:0] param_total;
        logic       line_done;
    } tok_out_t;

endpackage

>>> rtl/core/irc_line_tokenizer.sv
// irc line tokenizer: splits a message line into command and parameters
`timescale 1ns / 1ps
`include "assert_macros.svh"

// One byte of an IRC line (CR LF removed, last content byte flagged) enters per
// transaction and yields exactly one result transaction in the following cycle. A new
// byte is taken every cycle while the result register is empty or its result
// is taken in the same cycle, so the sustained rate is one byte per clock; the
// single result register between the per-byte decode and the output sets this
// figure. Word state clears after the flagged last byte, so the next line can
// follow immediately.
module irc_line_tokenizer #(
    parameter int CMD_LEN_MAX   = 16,
    parameter int PARAM_NUM_MAX = 15,
    parameter int PARAM_LEN_MAX = 512
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  byte_valid,
    output logic                  byte_ready,
    input  irc_tok_pkg::tok_in_t  byte_item,
    output logic                  result_valid,
    input  logic                  result_ready,
    output irc_tok_pkg::tok_out_t result_item
);

    localparam int PW = irc_tok_pkg::POS_W;
    localparam logic [PW-1:0] CMD_LIM   = PW'(CMD_LEN_MAX);
    localparam logic [PW-1:0] PARAM_LIM = PW'(PARAM_LEN_MAX);
    localparam logic [3:0]    NUM_LIM   = 4'(PARAM_NUM_MAX);

    logic          have_cmd_reg, have_cmd_next;
    logic [3:0]    pcount_reg, pcount_next;
    logic [PW-1:0] wpos_reg, wpos_next;
    logic          trail_reg, trail_next;
    logic          cur_cmd_reg, cur_cmd_next;
    logic          out_valid_reg, out_valid_next;
    irc_tok_pkg::tok_out_t out_reg, out_next;

    logic          accept;
    logic          is_space_br, is_trail_start, do_content, do_finish;
    logic          cur_cmd_eff;
    logic [PW-1:0] wpos_inc, wpos_after, fin_len;
    logic [3:0]    pidx;
    logic [PW-1:0] off;
    logic [1:0]    bkind, wkind;
    logic [PW-1:0] wlen;

    assign byte_ready = !out_valid_reg || result_ready;
    assign accept     = byte_valid && byte_ready;

    always_comb
    begin
        is_trail_start = !trail_reg && (wpos_reg == '0)
                         && (byte_item.data_byte == irc_tok_pkg::CH_COLON)
                         && !byte_item.last_byte;
        is_space_br    = !trail_reg && !is_trail_start
                         && (byte_item.data_byte == irc_tok_pkg::CH_SPACE);
        do_content     = !is_trail_start && !is_space_br;
        do_finish      = is_space_br || byte_item.last_byte;

        cur_cmd_eff = cur_cmd_reg;
        if (do_content && (wpos_reg == '0) && !trail_reg)
        begin
            cur_cmd_eff = !have_cmd_reg;
        end

        wpos_inc   = (wpos_reg < irc_tok_pkg::POS_SAT) ? wpos_reg + 1'b1 : wpos_reg;
        wpos_after = do_content ? wpos_inc : wpos_reg;
        fin_len    = is_space_br ? wpos_reg : wpos_after;

        bkind = irc_tok_pkg::BK_SEP;
        pidx  = '0;
        off   = '0;
        if (do_content)
        begin
            if (cur_cmd_eff && !trail_reg)
            begin
                if (wpos_reg < CMD_LIM)
                begin
                    bkind = irc_tok_pkg::BK_CMD;
                    off   = wpos_reg;
                end
                else
                begin
                    bkind = irc_tok_pkg::BK_DROPPED;
                end
            end
            else if ((pcount_reg < NUM_LIM) && (wpos_reg < PARAM_LIM))
            begin
                bkind = irc_tok_pkg::BK_PARAM;
                off   = wpos_reg;
                pidx  = pcount_reg;
            end
            else
            begin
                bkind = irc_tok_pkg::BK_DROPPED;
            end
        end

        // word completion, by a space or by the end of the line
        wkind         = irc_tok_pkg::WK_IGNORED;
        wlen          = '0;
        pcount_next   = pcount_reg;
        have_cmd_next = have_cmd_reg;
        if (do_finish)
        begin
            if (trail_reg || have_cmd_reg)
            begin
                if (pcount_reg < NUM_LIM)
                begin
                    wkind       = irc_tok_pkg::WK_PARAM;
                    wlen        = (fin_len < PARAM_LIM) ? fin_len : PARAM_LIM;
                    pidx        = pcount_reg;
                    pcount_next = pcount_reg + 1'b1;
                end
                else
                begin
                    wkind = irc_tok_pkg::WK_DROPPED;
                end
            end
            else if (fin_len != '0)
            begin
                wkind         = irc_tok_pkg::WK_CMD;
                wlen          = (fin_len < CMD_LIM) ? fin_len : CMD_LIM;
                have_cmd_next = 1'b1;
            end
        end

        trail_next   = trail_reg || is_trail_start;
        cur_cmd_next = (is_trail_start || is_space_br) ? 1'b0 : cur_cmd_eff;
        wpos_next    = is_space_br ? '0 : wpos_after;

        out_next.byte_out    = byte_item.data_byte;
        out_next.byte_kind   = bkind;
        out_next.param_index = pidx;
        out_next.byte_offset = off[8:0];
        out_next.word_done   = do_finish;
        out_next.word_kind   = wkind;
        out_next.word_length = wlen;
        out_next.param_total = pcount_next;
        out_next.line_done   = byte_item.last_byte;

        if (byte_item.last_byte)
        begin
            have_cmd_next = 1'b0;
            pcount_next   = '0;
            wpos_next     = '0;
            trail_next    = 1'b0;
            cur_cmd_next  = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_cmd_reg  <= 1'b0;
            pcount_reg    <= '0;
            wpos_reg      <= '0;
            trail_reg     <= 1'b0;
            cur_cmd_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                have_cmd_reg <= have_cmd_next;
                pcount_reg   <= pcount_next;
                wpos_reg     <= wpos_next;
                trail_reg    <= trail_next;
                cur_cmd_reg  <= cur_cmd_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_reg <= out_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result_item  = out_reg;

    `ASSERT_CLK(a_line_clears, clk, rst_n, accept && byte_item.last_byte |=> wpos_reg == '0 && pcount_reg == '0 && !trail_reg && !have_cmd_reg, "state not cleared after last byte")
    `ASSERT_CLK(a_word_fields, clk, rst_n, result_valid && !result_item.word_done |-> result_item.word_kind == irc_tok_pkg::WK_IGNORED && result_item.word_length == '0, "word fields set without completion")
    `ASSERT_CLK(a_pcount_lim, clk, rst_n, pcount_reg <= NUM_LIM, "parameter count beyond limit")
    `ASSERT_CLK(a_cmd_offset, clk, rst_n, result_valid && result_item.byte_kind == irc_tok_pkg::BK_CMD |-> {1'b0, result_item.byte_offset} < CMD_LIM, "command byte kept beyond length limit")
    `ASSERT_CLK(a_result_taken, clk, rst_n, result_valid && !result_ready |=> result_valid && $stable(result_item), "pending result lost or changed")

endmodule
